// ===== sv/linear_probe_hash_table_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the linear probe hash table unit
// Shared forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LPHT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpht check failed");

// next-cycle implication, checked out of reset
`define LPHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpht check failed");

`endif

// ===== sv/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and codes of the linear probe hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned SLOT_W = 5;
  localparam logic [7:0]  CHAR_A = 8'h61;  // 'a'

  // request codes (code 3 acts as lookup)
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // slot status codes (code 3 acts as tombstone)
  localparam logic [1:0] ST_NEVER = 2'd0;
  localparam logic [1:0] ST_TOMB  = 2'd1;
  localparam logic [1:0] ST_OCC   = 2'd2;

  typedef enum logic [2:0] {
    OC_DONE     = 3'd0,
    OC_NOTFOUND = 3'd1,
    OC_PRESENT  = 3'd2,
    OC_FULL     = 3'd3,
    OC_BADKEY   = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_DONE   = 3'b100
  } state_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] key;
  } slot_word_t;

endpackage

// ===== sv/linear_probe_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressing hash table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry a key (in_tdata) and a request (in_tuser: lookup,
//   insert, remove). Each word gives one result word: outcome and slot.
//   Slot status and key live together in one single-port RAM. A request
//   streams reads from its home slot, one slot per cycle, and checks each
//   returned entry in the cycle after its read is issued; an insert or remove
//   that changes the table ends with one write. A bad key skips the search
//   and goes straight to the done state. The block is ready for the next
//   word in the cycle after the result is loaded into the output register.
//   One request is in work at a time, so the RAM port and probe loop set
//   the throughput.
//   The output register holds a finished result while the next request is
//   already being accepted and probed; a stalled receiver stalls the
//   block only when a second result is ready.
//   Reset clears the per-slot valid flops, so every slot reads as never
//   used at once; there is no clearing pass. Keys are never reset.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_unit_assert.svh"

module linear_probe_hash_table_unit
  import lpht_pkg::*;
#(
  parameter int unsigned SLOTS = 26
) (
  input  logic        clk,
  input  logic        rst_n,
  // request word
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] key_bytes
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // result word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [2:0] outcome, [7:3] slot_index
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] ALL_CNT  = CNT_W'(SLOTS);

  state_t            state_r, state_nxt;
  logic [1:0]        req_r, req_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [IDX_W-1:0]  iss_idx_r, iss_idx_nxt;
  logic [CNT_W-1:0]  iss_cnt_r, iss_cnt_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]  rd_slot_r, rd_slot_nxt;
  logic [CNT_W-1:0]  eval_cnt_r, eval_cnt_nxt;
  logic              free_found_r, free_found_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  outcome_t          res_outcome_r, res_outcome_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  outcome_t          out_outcome_r, out_outcome_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [SLOTS-1:0]  valid_r, valid_nxt;

  logic              ram_en, ram_we;
  logic [IDX_W-1:0]  ram_addr;
  slot_word_t        ram_wdata, ram_rdata;

  logic [7:0]        low_byte;
  logic [8:0]        home_wide;
  logic              bad_key;
  logic [1:0]        rd_st;
  logic              rd_occ, rd_never, rd_match, at_cap, stop;
  logic              free_ok;
  logic [IDX_W-1:0]  free_slot, wr_addr;
  logic              is_ins, is_rem, do_write, issue, out_load;

  lpht_ram #(
    .WIDTH ($bits(slot_word_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // key check and home slot
  assign low_byte  = in_tdata[7:0];
  assign home_wide = {1'b0, low_byte} - {1'b0, CHAR_A};
  assign bad_key   = (low_byte < CHAR_A) || (home_wide >= 9'(SLOTS));

  // probe evaluation of the entry returned this cycle
  assign rd_st    = valid_r[rd_slot_r] ? ram_rdata.status : ST_NEVER;
  assign rd_occ   = (rd_st == ST_OCC);
  assign rd_never = (rd_st == ST_NEVER);
  assign rd_match = rd_occ && (ram_rdata.key == key_r);
  assign at_cap   = (eval_cnt_r == LAST_CNT);
  assign stop     = (state_r == S_SEARCH) && rd_pend_r && (rd_never || rd_match || at_cap);

  assign free_ok   = free_found_r || !rd_occ;
  assign free_slot = free_found_r ? free_idx_r : rd_slot_r;

  assign is_ins   = (req_r == REQ_INSERT);
  assign is_rem   = (req_r == REQ_REMOVE);
  assign do_write = stop && ((is_ins && !rd_match && free_ok) || (is_rem && rd_match));
  assign wr_addr  = is_ins ? free_slot : rd_slot_r;
  assign issue    = (state_r == S_SEARCH) && !stop && (iss_cnt_r < ALL_CNT);

  // RAM port: final write wins over a speculative read
  assign ram_we           = do_write;
  assign ram_en           = issue || do_write;
  assign ram_addr         = do_write ? wr_addr : iss_idx_r;
  assign ram_wdata.status = is_ins ? ST_OCC : ST_TOMB;
  assign ram_wdata.key    = key_r;

  assign in_tready = (state_r == S_IDLE);
  assign out_load  = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  // control and probe bookkeeping
  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    key_nxt         = key_r;
    iss_idx_nxt     = iss_idx_r;
    iss_cnt_nxt     = iss_cnt_r;
    rd_pend_nxt     = 1'b0;
    rd_slot_nxt     = rd_slot_r;
    eval_cnt_nxt    = eval_cnt_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    res_outcome_nxt = res_outcome_r;
    res_slot_nxt    = res_slot_r;
    valid_nxt       = valid_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt        = in_tuser;
          key_nxt        = in_tdata;
          iss_idx_nxt    = IDX_W'(home_wide);
          iss_cnt_nxt    = '0;
          eval_cnt_nxt   = '0;
          free_found_nxt = 1'b0;
          if (bad_key) begin
            res_outcome_nxt = OC_BADKEY;
            res_slot_nxt    = '0;
            state_nxt       = S_DONE;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        // stream the next read
        if (issue) begin
          rd_pend_nxt = 1'b1;
          rd_slot_nxt = iss_idx_r;
          iss_idx_nxt = (iss_idx_r == LAST_IDX) ? '0 : iss_idx_r + 1'b1;
          iss_cnt_nxt = iss_cnt_r + 1'b1;
        end
        if (rd_pend_r) begin
          eval_cnt_nxt = eval_cnt_r + 1'b1;
          if (!rd_occ && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = rd_slot_r;
          end
        end
        if (stop) begin
          state_nxt = S_DONE;
          priority if (rd_match) begin
            res_outcome_nxt = is_ins ? OC_PRESENT : OC_DONE;
            res_slot_nxt    = SLOT_W'(rd_slot_r);
          end else if (is_ins && free_ok) begin
            res_outcome_nxt = OC_DONE;
            res_slot_nxt    = SLOT_W'(free_slot);
          end else if (is_ins) begin
            res_outcome_nxt = OC_FULL;
            res_slot_nxt    = '0;
          end else begin
            res_outcome_nxt = OC_NOTFOUND;
            res_slot_nxt    = '0;
          end
          if (do_write) begin
            valid_nxt[wr_addr] = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_outcome_nxt = out_outcome_r;
    out_slot_nxt    = out_slot_r;
    out_tvalid_nxt  = out_tvalid_r;
    if (out_load) begin
      out_outcome_nxt = res_outcome_r;
      out_slot_nxt    = res_slot_r;
      out_tvalid_nxt  = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rd_pend_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
      valid_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      valid_r      <= valid_nxt;
    end
  end

  // payload and probe registers
  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    key_r         <= key_nxt;
    iss_idx_r     <= iss_idx_nxt;
    iss_cnt_r     <= iss_cnt_nxt;
    rd_slot_r     <= rd_slot_nxt;
    eval_cnt_r    <= eval_cnt_nxt;
    free_found_r  <= free_found_nxt;
    free_idx_r    <= free_idx_nxt;
    res_outcome_r <= res_outcome_nxt;
    res_slot_r    <= res_slot_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_slot_r    <= out_slot_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_slot_r, out_outcome_r};

  // checks
  `LPHT_ASSERT_NOW(a_write_after_probe, ram_we, (state_r == S_SEARCH) && rd_pend_r)
  `LPHT_ASSERT_NOW(a_probe_cap, state_r == S_SEARCH, eval_cnt_r < ALL_CNT)
  `LPHT_ASSERT_NEXT(a_write_marks_valid, ram_we, valid_r[$past(ram_addr)])
  `LPHT_ASSERT_NOW(a_badkey_no_slot, out_tvalid && (out_tdata[2:0] == OC_BADKEY), out_tdata[7:3] == '0)

endmodule

// ===== sv/lpht_ram.sv =====
// ----------------------------------------------------------------------------
// lpht_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int unsigned WIDTH = 66,
  parameter int unsigned DEPTH = 26
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write or registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== tb/tb_linear_probe_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table_unit
// Self-checking bench: directed and random traffic against a shadow hash table.
// Request words go in from a backlog queue with random gaps. Each accepted
// request is applied to a local copy of the slot table, and the predicted
// outcome and slot are queued. Result words are taken with random stalls
// and compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_linear_probe_hash_table_unit;
  import lpht_pkg::*;

  localparam int unsigned SLOTS      = 26;
  localparam int unsigned RANDOM_N   = 1750;
  localparam int unsigned POOL_N     = 48;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYC  = 40;
  localparam logic [1:0]  REQ_ALIAS  = 2'd3;  // spare code, behaves as lookup

  typedef struct {
    logic [1:0]  req;
    logic [63:0] key;
  } hash_req_t;

  typedef struct {
    outcome_t   oc;
    logic [4:0] slot;
  } hash_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  // shadow copy of the slot table
  logic [1:0]  tbl_status [SLOTS];
  logic [63:0] tbl_key    [SLOTS];

  hash_req_t    req_backlog[$];
  hash_result_t pending_results[$];
  logic [63:0]  live_keys[$];
  logic [63:0]  key_pool [POOL_N];

  int unsigned words_issued   = 0;
  int unsigned words_accepted = 0;
  int unsigned req_total      = 0;
  int unsigned send_gap       = 0;
  int unsigned recv_stall     = 0;
  int unsigned idle_cycles    = 0;
  int unsigned cyc            = 0;
  int unsigned errors         = 0;

  linear_probe_hash_table_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // apply one request to the shadow table and return its result
  function automatic hash_result_t table_request(logic [1:0] req, logic [63:0] key);
    hash_result_t res;
    int           home;
    int           i;
    int           hit;
    bit           found;
    bit           placed;
    res.oc   = OC_DONE;
    res.slot = '0;
    found    = 1'b0;
    placed   = 1'b0;
    hit      = 0;
    if (key[7:0] < CHAR_A || int'(key[7:0]) - int'(CHAR_A) >= SLOTS) begin
      res.oc = OC_BADKEY;
      return res;
    end
    home = int'(key[7:0]) - int'(CHAR_A);
    // search: stop at a never-used slot or after SLOTS probes
    i = home;
    for (int n = 0; n < SLOTS; n++) begin
      if (tbl_status[i] == ST_NEVER) break;
      if (tbl_status[i] == ST_OCC && tbl_key[i] == key) begin
        found = 1'b1;
        hit   = i;
        break;
      end
      i = (i + 1 == SLOTS) ? 0 : i + 1;
    end
    case (req)
      REQ_INSERT: begin
        if (found) begin
          res.oc   = OC_PRESENT;
          res.slot = 5'(hit);
        end else begin
          // first slot from home that is not occupied
          i = home;
          for (int n = 0; n < SLOTS; n++) begin
            if (tbl_status[i] != ST_OCC) begin
              tbl_status[i] = ST_OCC;
              tbl_key[i]    = key;
              placed        = 1'b1;
              break;
            end
            i = (i + 1 == SLOTS) ? 0 : i + 1;
          end
          res.oc   = placed ? OC_DONE : OC_FULL;
          res.slot = placed ? 5'(i) : 5'd0;
        end
      end
      REQ_REMOVE: begin
        if (found) begin
          tbl_status[hit] = ST_TOMB;
          res.slot        = 5'(hit);
        end else begin
          res.oc = OC_NOTFOUND;
        end
      end
      default: begin
        if (found) res.slot = 5'(hit);
        else res.oc = OC_NOTFOUND;
      end
    endcase
    return res;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // home slot biased toward both ends of the table for clusters and wrap
  function automatic int unsigned pick_home();
    int unsigned r;
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, SLOTS - 1);
    r = $urandom_range(0, 5);
    return (r < 3) ? r : SLOTS - 6 + r;
  endfunction

  function automatic logic [63:0] make_key(int unsigned home);
    logic [63:0] k;
    int unsigned n;
    k = '0;
    if ($urandom_range(0, 2) == 0) begin
      k = {$urandom, $urandom};
    end else begin
      n = $urandom_range(0, 7);
      for (int j = 1; j <= n; j++) k[8*j +: 8] = CHAR_A + 8'($urandom_range(0, 25));
    end
    k[7:0] = CHAR_A + 8'(home);
    return k;
  endfunction

  function automatic void add_req(logic [1:0] req, logic [63:0] key);
    hash_req_t r;
    r.req = req;
    r.key = key;
    req_backlog.push_back(r);
    if (req == REQ_INSERT) live_keys.push_back(key);
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < 20) $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask

  // long stretches without any idling on either side
  function automatic bit calm_phase();
    return (cyc % 3000) < 400;
  endfunction

  // request driver: hold a word until taken, then gap or present the next
  always @(negedge clk) begin
    hash_req_t r;
    if (rst_n && !(in_tvalid && words_accepted != words_issued)) begin
      if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap  <= send_gap - 1;
      end else if (req_backlog.size() > 0) begin
        r = req_backlog.pop_front();
        in_tvalid    <= 1'b1;
        in_tdata     <= r.key;
        in_tuser     <= r.req;
        words_issued <= words_issued + 1;
        send_gap     <= (calm_phase() || $urandom_range(0, 99) >= 35) ? 0 : idle_len();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (recv_stall > 0) begin
        out_tready <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else if (!calm_phase() && $urandom_range(0, 99) < 20) begin
        out_tready <= 1'b0;
        recv_stall <= idle_len() - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor: check result words, predict for accepted request words
  always @(posedge clk) begin
    hash_result_t want;
    hash_result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", out_tdata));
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[2:0] !== want.oc)
            report_mismatch($sformatf("outcome %0d, want %0d", out_tdata[2:0], want.oc));
          if (out_tdata[7:3] !== want.slot)
            report_mismatch($sformatf("slot %0d, want %0d", out_tdata[7:3], want.slot));
        end
      end
      if (in_tvalid && in_tready) begin
        got = table_request(in_tuser, in_tdata);
        pending_results.push_back(got);
        words_accepted <= words_accepted + 1;
      end
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("[linear_probe_hash_table_unit] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned kind;
    int unsigned directed_n;
    logic [63:0] k;
    logic [1:0]  rq;

    for (int s = 0; s < SLOTS; s++) begin
      tbl_status[s] = ST_NEVER;
      tbl_key[s]    = '0;
    end
    for (int p = 0; p < POOL_N; p++) key_pool[p] = make_key(pick_home());

    // directed: bad keys, each request kind, collisions, tombstones, wrap
    add_req(REQ_LOOKUP, 64'h61);                    // empty table
    add_req(REQ_LOOKUP, 64'h0);                     // low byte zero
    add_req(REQ_INSERT, 64'h60);                    // just below 'a'
    add_req(REQ_REMOVE, 64'h7b);                    // just past 'z'
    add_req(REQ_INSERT, 64'hffff_ffff_ffff_ffff);   // all ones
    add_req(REQ_INSERT, 64'h61);
    add_req(REQ_INSERT, 64'h61);                    // duplicate
    add_req(REQ_INSERT, 64'hffff_ffff_ffff_ff61);   // same home, next slot
    add_req(REQ_ALIAS,  64'hffff_ffff_ffff_ff61);   // spare code as lookup
    add_req(REQ_LOOKUP, 64'h61);
    add_req(REQ_REMOVE, 64'h61);                    // leaves a tombstone
    add_req(REQ_REMOVE, 64'h61);                    // already gone
    add_req(REQ_LOOKUP, 64'hffff_ffff_ffff_ff61);   // probes past tombstone
    add_req(REQ_INSERT, 64'h8000_0000_0000_0061);   // reuses the tombstone
    add_req(REQ_INSERT, 64'h7a);                    // last slot
    add_req(REQ_INSERT, 64'h617a);                  // wraps to the front
    add_req(REQ_LOOKUP, 64'h617a);
    add_req(REQ_REMOVE, 64'h7a);
    add_req(REQ_LOOKUP, 64'h617a);                  // wrap across tombstone
    add_req(REQ_REMOVE, 64'h8000_0000_0000_0061);
    add_req(REQ_ALIAS,  64'h5a);                    // bad key, spare code
    directed_n = req_backlog.size();

    // random: pooled traffic, fill and drain bursts, noise, near misses
    while (req_backlog.size() < directed_n + RANDOM_N) begin
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        kind = $urandom_range(0, 9);
        rq = (kind < 4) ? REQ_INSERT : (kind < 7) ? REQ_LOOKUP :
             (kind < 9) ? REQ_REMOVE : REQ_ALIAS;
        add_req(rq, key_pool[$urandom_range(0, POOL_N - 1)]);
      end else if (pick < 62) begin
        // fill until the table reports full
        repeat (SLOTS + 4) add_req(REQ_INSERT, make_key(pick_home()));
        repeat (4) add_req(REQ_LOOKUP, make_key(pick_home()));
      end else if (pick < 65) begin
        // remove everything inserted so far, then search a tombstone table
        while (live_keys.size() > 0) add_req(REQ_REMOVE, live_keys.pop_front());
        repeat (3) add_req(REQ_LOOKUP, make_key(pick_home()));
      end else if (pick < 78) begin
        add_req(2'($urandom_range(0, 3)), {$urandom, $urandom});
      end else if (pick < 88) begin
        k = key_pool[$urandom_range(0, POOL_N - 1)];
        add_req(REQ_REMOVE, k);
        add_req(REQ_LOOKUP, k);
        add_req(REQ_INSERT, k);
      end else begin
        // same home, one upper bit different
        k = key_pool[$urandom_range(0, POOL_N - 1)];
        k[$urandom_range(8, 63)] ^= 1'b1;
        add_req(2'($urandom_range(0, 3)), k);
      end
    end
    req_total = req_backlog.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (words_accepted < req_total || pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (errors == 0) begin
      $display("[linear_probe_hash_table_unit] OK");
    end else begin
      $display("[linear_probe_hash_table_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== linear_probe_hash_table_unit.f =====
+incdir+sv
sv/lpht_pkg.sv
sv/lpht_ram.sv
sv/linear_probe_hash_table_unit.sv
tb/tb_linear_probe_hash_table_unit.sv
